/* src/swms_pkg.sv */
// Shared constants, types and helper functions of the sliding window minimum block.
package swms_pkg;

  // Deepest window the queue storage supports.
  localparam int WINDOW_MAX = 1024;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX) + 1;
  localparam int FILL_W     = CNT_W + 1;

  localparam int DATA_W     = 32;
  localparam int SUM_W      = 64;
  localparam int WIN_W      = 11;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_A       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_B       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_C       = 3'd4;

  // Strobes from the queue sequencer to the value generator.
  typedef struct packed {
    logic load;    // input beat accepted: capture sample and products
    logic commit;  // form the new value and advance the history
  } gen_ctl_t;

  // New value and item count from the value generator.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [31:0]       items_seen;
  } gen_res_t;

  // Signed minimum of two 32-bit words.
  function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] m;
    m = ($signed(a) < $signed(b)) ? a : b;
    return m;
  endfunction

endpackage

/* src/swms_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module swms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/swms_gen.sv */
// Value generator: seeded input samples, then a second-order recurrence.
module swms_gen (
  input  logic                     clk,
  input  logic                     rst_n,
  input  swms_pkg::gen_ctl_t       ctl,
  input  logic [swms_pkg::DATA_W-1:0] sample,
  input  logic [31:0]              seed_count,
  input  logic [swms_pkg::DATA_W-1:0] gen_a,
  input  logic [swms_pkg::DATA_W-1:0] gen_b,
  input  logic [swms_pkg::DATA_W-1:0] gen_c,
  output swms_pkg::gen_res_t       res
);

  logic [swms_pkg::DATA_W-1:0] prod_a_r, prod_b_r, sample_r;
  logic                        seeded_r;
  logic [swms_pkg::DATA_W-1:0] last_r, before_r, value_r;
  logic [31:0]                 seen_r;
  logic [swms_pkg::DATA_W-1:0] value_nxt;

  // The new value: the captured sample while seeding, else the wrapped recurrence.
  always_comb begin
    if (seeded_r) begin
      value_nxt = sample_r;
    end else begin
      value_nxt = prod_a_r + prod_b_r + gen_c;
    end
  end

  // Products are registered at the input beat; history advances on commit.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_a_r <= swms_pkg::DATA_W'(gen_a * before_r);
      prod_b_r <= swms_pkg::DATA_W'(gen_b * last_r);
      sample_r <= sample;
    end
    if (ctl.commit) begin
      value_r <= value_nxt;
    end
  end

  // History and item counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      before_r <= '0;
      seen_r   <= '0;
      seeded_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        seeded_r <= (seen_r < seed_count);
      end
      if (ctl.commit) begin
        last_r   <= value_nxt;
        before_r <= last_r;
        if (seen_r != 32'hFFFF_FFFF) begin
          seen_r <= seen_r + 32'd1;
        end
      end
    end
  end

  assign res.value      = value_r;
  assign res.items_seen = seen_r;

endmodule

/* src/sliding_window_min_sum_core.sv */
// Top level: configuration, queue sequencer and stack memories of the window minimum.
//
// Streams values through a sliding window and reports the minimum of the
// most recent window_size values together with a wrapping 64-bit sum of all
// minima reported so far. The input channel (in_valid/in_ready) carries one
// sample per beat; the result channel (out_valid/out_ready) carries one
// window_min/running_sum pair per beat, and no result is made until
// window_size values have entered. The cfg_we/cfg_index/cfg_wdata port writes
// the configuration registers; the user must see that it is used only while
// idle, as the block itself does not enforce this. An accepted item is loaded
// into the value generator, committed, checked against the window, pushed
// and reported to the output register. Each value that leaves is popped, and
// the new top of the older stack is then fetched if one remains; when the
// older stack is empty, it is first refilled from the newer stack, one value
// per read, through the single read port of each stack memory. Refills happen
// at most once per window. The output register lets the next item be accepted
// while a result waits; a stalled receiver only holds the sequencer when the
// next result is ready. Reset empties the queue, zeroes history, counter and
// sum, and sets the window to one; the stack memories need no clearing.
module sliding_window_min_sum_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_window_min,
  output logic signed [63:0]          out_running_sum,
  input  logic                        cfg_we,
  input  logic [swms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_wdata
);

  localparam int AW = swms_pkg::ADDR_W;
  localparam int CW = swms_pkg::CNT_W;
  localparam int FW = swms_pkg::FILL_W;
  localparam int DW = swms_pkg::DATA_W;
  localparam int SW = swms_pkg::SUM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_VAL, S_CHK, S_POP, S_XFER, S_TOPRD, S_RES
  } state_t;

  // Configuration registers.
  logic [swms_pkg::WIN_W-1:0] window_size_r;
  logic [31:0]                seed_count_r;
  logic [DW-1:0]              gen_a_r, gen_b_r, gen_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swms_pkg::WIN_W'(1);
      seed_count_r  <= '0;
      gen_a_r       <= '0;
      gen_b_r       <= '0;
      gen_c_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        swms_pkg::CFG_WINDOW_SIZE: window_size_r <= cfg_wdata[swms_pkg::WIN_W-1:0];
        swms_pkg::CFG_SEED_COUNT:  seed_count_r  <= cfg_wdata;
        swms_pkg::CFG_GEN_A:       gen_a_r       <= cfg_wdata;
        swms_pkg::CFG_GEN_B:       gen_b_r       <= cfg_wdata;
        swms_pkg::CFG_GEN_C:       gen_c_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective window, clamped to one through the storage depth.
  logic [CW-1:0] win;

  always_comb begin
    if (window_size_r == '0) begin
      win = CW'(1);
    end else if (32'(window_size_r) > 32'(swms_pkg::WINDOW_MAX)) begin
      win = CW'(swms_pkg::WINDOW_MAX);
    end else begin
      win = CW'(window_size_r);
    end
  end

  // Sequencer and datapath registers.
  state_t         state_r, state_nxt;
  logic [CW-1:0]  newer_count_r, newer_count_nxt;
  logic [CW-1:0]  older_count_r, older_count_nxt;
  logic [DW-1:0]  newer_min_r, newer_min_nxt;
  logic [DW-1:0]  older_top_r, older_top_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic           final_r, final_nxt;
  logic [SW-1:0]  total_r, total_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  out_min_r, out_min_nxt;
  logic [SW-1:0]  out_sum_r, out_sum_nxt;

  // Memory ports.
  logic          newer_we, older_we;
  logic [AW-1:0] newer_waddr, newer_raddr, older_waddr, older_raddr;
  logic [DW-1:0] newer_wdata, newer_rdata, older_wdata, older_rdata;

  swms_pkg::gen_ctl_t gen_ctl;
  swms_pkg::gen_res_t gen_res;

  // Derived values.
  logic [FW-1:0] fill;
  logic [CW-1:0] newer_dec, older_dec2;
  logic [DW-1:0] xfer_min, res_min;

  assign fill       = FW'(newer_count_r) + FW'(older_count_r);
  assign newer_dec  = newer_count_r - CW'(1);
  assign older_dec2 = older_count_r - CW'(2);
  assign xfer_min   = (older_count_r == '0) ? newer_rdata
                                            : swms_pkg::smin(newer_rdata, older_top_r);
  assign res_min    = (older_count_r != '0) ? swms_pkg::smin(newer_min_r, older_top_r)
                                            : newer_min_r;

  swms_gen u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (gen_ctl),
    .sample     (in_sample),
    .seed_count (seed_count_r),
    .gen_a      (gen_a_r),
    .gen_b      (gen_b_r),
    .gen_c      (gen_c_r),
    .res        (gen_res)
  );

  // Newer stack holds pushed values; its running minimum lives in newer_min_r.
  swms_ram #(.WIDTH(DW), .DEPTH(swms_pkg::WINDOW_MAX)) u_newer_ram (
    .clk   (clk),
    .we    (newer_we),
    .waddr (newer_waddr),
    .wdata (newer_wdata),
    .raddr (newer_raddr),
    .rdata (newer_rdata)
  );

  // Older stack holds running minima toward the oldest value; its top is cached.
  swms_ram #(.WIDTH(DW), .DEPTH(swms_pkg::WINDOW_MAX)) u_older_ram (
    .clk   (clk),
    .we    (older_we),
    .waddr (older_waddr),
    .wdata (older_wdata),
    .raddr (older_raddr),
    .rdata (older_rdata)
  );

  // Next-state logic of the queue sequencer.
  always_comb begin
    state_nxt       = state_r;
    newer_count_nxt = newer_count_r;
    older_count_nxt = older_count_r;
    newer_min_nxt   = newer_min_r;
    older_top_nxt   = older_top_r;
    rd_pend_nxt     = 1'b0;
    final_nxt       = final_r;
    total_nxt       = total_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_min_nxt     = out_min_r;
    out_sum_nxt     = out_sum_r;
    newer_we        = 1'b0;
    newer_waddr     = newer_count_r[AW-1:0];
    newer_wdata     = gen_res.value;
    newer_raddr     = newer_dec[AW-1:0];
    older_we        = 1'b0;
    older_waddr     = older_count_r[AW-1:0];
    older_wdata     = xfer_min;
    older_raddr     = older_dec2[AW-1:0];
    gen_ctl         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          gen_ctl.load = 1'b1;
          state_nxt    = S_VAL;
        end
      end

      S_VAL: begin
        gen_ctl.commit = 1'b1;
        state_nxt      = S_CHK;
      end

      // Drop oldest values until the new one fits, then push it.
      S_CHK: begin
        if (fill >= FW'(win)) begin
          final_nxt = 1'b0;
          state_nxt = S_POP;
        end else begin
          newer_we        = 1'b1;
          newer_min_nxt   = (newer_count_r != '0)
                            ? swms_pkg::smin(gen_res.value, newer_min_r) : gen_res.value;
          newer_count_nxt = newer_count_r + CW'(1);
          state_nxt       = S_RES;
        end
      end

      // Remove the oldest value; refill the older stack first when it is empty.
      S_POP: begin
        if (older_count_r == '0) begin
          state_nxt = S_XFER;
        end else begin
          older_count_nxt = older_count_r - CW'(1);
          if (older_count_r > CW'(1)) begin
            state_nxt = S_TOPRD;
          end else begin
            state_nxt = final_r ? S_IDLE : S_CHK;
          end
        end
      end

      // Pop newer entries from the top, one read a cycle, into the older stack.
      S_XFER: begin
        if (newer_count_r != '0) begin
          newer_count_nxt = newer_count_r - CW'(1);
          rd_pend_nxt     = 1'b1;
        end
        if (rd_pend_r) begin
          older_we        = 1'b1;
          older_top_nxt   = xfer_min;
          older_count_nxt = older_count_r + CW'(1);
        end
        if (newer_count_r == '0 && !rd_pend_r) begin
          state_nxt = S_POP;
        end
      end

      // The read of the new older top, issued during the pop, returns here.
      S_TOPRD: begin
        older_top_nxt = older_rdata;
        state_nxt     = final_r ? S_IDLE : S_CHK;
      end

      // Report the window minimum once the window has filled.
      S_RES: begin
        if (gen_res.items_seen < 32'(win)) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          total_nxt     = total_r + {{(SW-DW){res_min[DW-1]}}, res_min};
          out_valid_nxt = 1'b1;
          out_min_nxt   = res_min;
          out_sum_nxt   = total_nxt;
          if (fill == FW'(win)) begin
            final_nxt = 1'b1;
            state_nxt = S_POP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      newer_count_r <= '0;
      older_count_r <= '0;
      rd_pend_r     <= 1'b0;
      final_r       <= 1'b0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      newer_count_r <= newer_count_nxt;
      older_count_r <= older_count_nxt;
      rd_pend_r     <= rd_pend_nxt;
      final_r       <= final_nxt;
      total_r       <= total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    newer_min_r <= newer_min_nxt;
    older_top_r <= older_top_nxt;
    out_min_r   <= out_min_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_window_min  = out_min_r;
  assign out_running_sum = out_sum_r;

endmodule
